@@ rtl/drt_pkg.sv @@
// Package for the task-graph ready tracker: sizes, opcodes, result kinds.
// No dependencies.
package drt_pkg;
  localparam int MaxNodes = 32;
  localparam int MaxEdges = 256;
  localparam int NodeW = $clog2(MaxNodes);
  localparam int EdgeW = $clog2(MaxEdges);
  localparam int DegW = EdgeW + 1;

  localparam logic [2:0] OP_ADD_NODE = 3'd0;
  localparam logic [2:0] OP_ADD_EDGE = 3'd1;
  localparam logic [2:0] OP_MARK_DONE = 3'd2;
  localparam logic [2:0] OP_MARK_UNDONE = 3'd3;
  localparam logic [2:0] OP_QUERY = 3'd4;
  localparam logic [2:0] OP_LIST = 3'd5;
  localparam logic [2:0] OP_SORT = 3'd6;
  localparam logic [2:0] OP_SPARE = 3'd7;

  localparam logic [1:0] KIND_REPLY = 2'd0;
  localparam logic [1:0] KIND_ID = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] value;
    logic [5:0] total;
    logic last;
  } res_t;
endpackage

@@ rtl/drt_edge_mem.sv @@
// Edge store: one synchronous memory of source/destination pairs.
// Depends on drt_pkg.
module drt_edge_mem (
  input  logic clk,
  input  logic we,
  input  logic [drt_pkg::EdgeW-1:0] waddr,
  input  logic [2*drt_pkg::NodeW-1:0] wdata,
  input  logic [drt_pkg::EdgeW-1:0] raddr,
  output logic [2*drt_pkg::NodeW-1:0] rdata
);
  logic [2*drt_pkg::NodeW-1:0] mem [drt_pkg::MaxEdges];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/drt_deg_mem.sv @@
// Indegree scratch store: one synchronous memory, one port read, one write.
// Depends on drt_pkg.
module drt_deg_mem (
  input  logic clk,
  input  logic we,
  input  logic [drt_pkg::NodeW-1:0] waddr,
  input  logic [drt_pkg::DegW-1:0] wdata,
  input  logic [drt_pkg::NodeW-1:0] raddr,
  output logic [drt_pkg::DegW-1:0] rdata
);
  logic [drt_pkg::DegW-1:0] mem [drt_pkg::MaxNodes];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/drt_queue_mem.sv @@
// Sort queue store: one synchronous memory of node ids.
// Depends on drt_pkg.
module drt_queue_mem (
  input  logic clk,
  input  logic we,
  input  logic [drt_pkg::NodeW-1:0] waddr,
  input  logic [drt_pkg::NodeW-1:0] wdata,
  input  logic [drt_pkg::NodeW-1:0] raddr,
  output logic [drt_pkg::NodeW-1:0] rdata
);
  logic [drt_pkg::NodeW-1:0] mem [drt_pkg::MaxNodes];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/dag_ready_tracker_topo_sort.sv @@
// Top level of the task-graph ready tracker and topological sorter.
// Depends on drt_pkg, drt_edge_mem, drt_deg_mem, drt_queue_mem.
//
// Usage:
//   One input channel (op, node_id, other_id, max_out) and one result channel
//   (result_kind, value, node_total, last), both valid/ready. An op gives one
//   or more results; the last carries last=1. One op runs at a time.
//   Add node, add edge, mark done/undone and unused op: the result is loaded
//   from the wait state that follows the input transfer.
//   Query ready: each edge is read and then checked, one edge at a time.
//   List ready: one edge pass per node.
//   Topo sort: clear the indegrees, count them in one edge pass, seed the
//   queue, then per emitted node a pop and an edge pass; the edge read and
//   the indegree read-modify-write set the pace.
//   Each result waits in an output register; while the receiver stalls the
//   next result holds, and the input stays closed until the last result of
//   the op has gone. Reset clears the node count, edge count and done marks;
//   the memories need no clearing pass.
module dag_ready_tracker_topo_sort (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [2:0] op,
  input  logic [5:0] node_id,
  input  logic [5:0] other_id,
  input  logic [5:0] max_out,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] result_kind,
  output logic [6:0] value,
  output logic [5:0] node_total,
  output logic last
);
  localparam int NW = drt_pkg::NodeW;
  localparam int EW = drt_pkg::EdgeW;
  localparam int DW = drt_pkg::DegW;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_RD     = 10'b0000000010,
    S_CHK    = 10'b0000000100,
    S_CLR    = 10'b0000001000,
    S_CNT    = 10'b0000010000,
    S_SEED   = 10'b0000100000,
    S_POP    = 10'b0001000000,
    S_REL    = 10'b0010000000,
    S_OUT    = 10'b0100000000,
    S_WAIT   = 10'b1000000000
  } state_t;

  state_t state;
  logic [2:0] op_r;
  logic [5:0] id_r, lim;
  logic [drt_pkg::MaxNodes-1:0] done_bits;
  logic [5:0] node_count;
  logic [EW:0] edge_count;
  logic [EW:0] eidx;
  logic [5:0] node;
  logic [5:0] cnt;
  logic [5:0] head, tail;
  logic [NW-1:0] cur;
  logic phase, pend, rdy;
  logic [1:0] seed_ph;
  logic [1:0] rmw_ph;
  logic res_load;
  drt_pkg::res_t res;
  logic ret_idle, is_final;

  logic e_we; logic [EW-1:0] e_ra; logic [2*NW-1:0] e_rd;
  logic d_we; logic [NW-1:0] d_wa, d_ra; logic [DW-1:0] d_wd, d_rd;
  logic q_we; logic [NW-1:0] q_wa, q_ra, q_wd, q_rd;

  wire [NW-1:0] e_src = e_rd[2*NW-1:NW];
  wire [NW-1:0] e_dst = e_rd[NW-1:0];
  wire edge_ok = (node_id < node_count) && (other_id < node_count) &&
                 (edge_count < (EW+1)'(drt_pkg::MaxEdges));
  wire node_ok = node_count < 6'(drt_pkg::MaxNodes);
  wire id_ok = node_id < node_count;
  wire out_free = !out_valid || out_ready;
  wire ready_ok = (id_r < node_count) && !done_bits[id_r[NW-1:0]];

  drt_edge_mem u_edge (.clk, .we(e_we), .waddr(edge_count[EW-1:0]),
    .wdata({node_id[NW-1:0], other_id[NW-1:0]}), .raddr(e_ra), .rdata(e_rd));
  drt_deg_mem u_deg (.clk, .we(d_we), .waddr(d_wa), .wdata(d_wd),
    .raddr(d_ra), .rdata(d_rd));
  drt_queue_mem u_q (.clk, .we(q_we), .waddr(q_wa), .wdata(q_wd),
    .raddr(q_ra), .rdata(q_rd));

  assign pend = out_valid && !out_ready;
  assign in_ready = (state == S_IDLE) && !out_valid;
  assign e_we = in_valid && in_ready && op == drt_pkg::OP_ADD_EDGE && edge_ok;
  assign e_ra = eidx[EW-1:0];
  assign q_ra = head[NW-1:0];
  assign result_kind = res.kind;
  assign value = res.value;
  assign node_total = res.total;
  assign last = res.last;

  always_comb begin
    d_we = 1'b0; d_wa = node[NW-1:0]; d_wd = '0; d_ra = e_dst;
    q_we = 1'b0; q_wa = tail[NW-1:0]; q_wd = node[NW-1:0];
    res_load = 1'b0;
    case (state)
      S_CLR: d_we = 1'b1;
      S_CNT: if (rmw_ph == 2'd2) begin
        d_we = 1'b1; d_wa = e_dst; d_wd = d_rd + 1'b1;
      end
      S_SEED: begin
        d_ra = node[NW-1:0];
        q_we = (seed_ph == 2'd2) && (d_rd == '0);
      end
      S_REL: if (rmw_ph == 2'd2 && e_src == cur && d_rd != '0) begin
        d_we = 1'b1; d_wa = e_dst; d_wd = d_rd - 1'b1;
        q_we = (d_rd == DW'(1)) && (tail < 6'(drt_pkg::MaxNodes));
        q_wd = e_dst;
      end
      S_WAIT: res_load = out_free;
      S_CHK: res_load = (op_r != drt_pkg::OP_QUERY) && out_free && rdy && ready_ok;
      S_POP: res_load = !(head >= tail || cnt >= lim) && out_free && phase;
      S_OUT: res_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0; done_bits <= '0;
      node_count <= '0; edge_count <= '0;
    end else begin
      out_valid <= res_load || pend;
      case (state)
        S_IDLE: if (in_valid && in_ready) begin
          op_r <= op; lim <= max_out;
          id_r <= (op == drt_pkg::OP_LIST) ? 6'd0 : node_id;
          eidx <= '0; node <= '0; cnt <= '0; phase <= 1'b0; rdy <= 1'b1;
          head <= '0; tail <= '0; seed_ph <= '0; rmw_ph <= '0;
          res.kind <= drt_pkg::KIND_REPLY; res.last <= 1'b1;
          res.total <= (op == drt_pkg::OP_ADD_NODE && node_ok) ?
                       node_count + 1'b1 : node_count;
          case (op)
            drt_pkg::OP_ADD_NODE: begin
              state <= S_WAIT;
              res.value <= node_ok ? {1'b0, node_count} : 7'h7f;
              if (node_ok) begin
                done_bits[node_count[NW-1:0]] <= 1'b0;
                node_count <= node_count + 1'b1;
              end
            end
            drt_pkg::OP_ADD_EDGE: begin
              state <= S_WAIT;
              res.value <= edge_ok ? 7'd0 : 7'h7f;
              if (edge_ok) edge_count <= edge_count + 1'b1;
            end
            drt_pkg::OP_MARK_DONE, drt_pkg::OP_MARK_UNDONE: begin
              state <= S_WAIT;
              res.value <= id_ok ? 7'd0 : 7'h7f;
              if (id_ok) done_bits[node_id[NW-1:0]] <= (op == drt_pkg::OP_MARK_DONE);
            end
            drt_pkg::OP_QUERY: state <= S_RD;
            drt_pkg::OP_LIST: state <= S_RD;
            drt_pkg::OP_SORT: state <= (max_out == '0) ? S_OUT : S_CLR;
            default: begin
              state <= S_WAIT; res.value <= 7'h7f;
            end
          endcase
        end
        S_WAIT: if (out_free) state <= S_IDLE;
        // ready check of node id_r: read edge, then check
        S_RD: begin
          if (op_r == drt_pkg::OP_LIST &&
              (id_r >= node_count || cnt >= lim)) state <= S_OUT;
          else if (eidx >= edge_count) begin
            phase <= 1'b0; state <= S_CHK;
          end else if (phase) begin
            if (e_dst == id_r[NW-1:0] && !done_bits[e_src]) rdy <= 1'b0;
            eidx <= eidx + 1'b1; phase <= 1'b0;
          end else phase <= 1'b1;
        end
        S_CHK: if (op_r == drt_pkg::OP_QUERY) begin
          res.value <= {6'd0, rdy && ready_ok}; state <= S_WAIT;
        end else if (out_free) begin
          if (rdy && ready_ok) begin
            res.kind <= drt_pkg::KIND_ID; res.last <= 1'b0;
            res.value <= {1'b0, id_r}; cnt <= cnt + 1'b1;
          end
          id_r <= id_r + 1'b1; eidx <= '0; rdy <= 1'b1; state <= S_RD;
        end
        S_CLR: if (node + 1'b1 >= node_count || node_count == '0) begin
          node <= '0; state <= S_CNT;
        end else node <= node + 1'b1;
        S_CNT: if (eidx >= edge_count) begin
          rmw_ph <= '0; state <= S_SEED;
        end else if (rmw_ph == 2'd2) begin
          eidx <= eidx + 1'b1; rmw_ph <= '0;
        end else rmw_ph <= rmw_ph + 1'b1;
        S_SEED: if (node >= node_count) state <= S_POP;
        else if (seed_ph == 2'd2) begin
          if (d_rd == '0) tail <= tail + 1'b1;
          node <= node + 1'b1; seed_ph <= '0;
        end else seed_ph <= seed_ph + 1'b1;
        S_POP: if (head >= tail || cnt >= lim) state <= S_OUT;
        else if (out_free) begin
          if (phase) begin
            cur <= q_rd; head <= head + 1'b1; cnt <= cnt + 1'b1;
            res.kind <= drt_pkg::KIND_ID; res.last <= 1'b0;
            res.value <= {2'b0, q_rd};
            eidx <= '0; phase <= 1'b0; state <= S_REL;
          end else phase <= 1'b1;
        end
        S_REL: if (eidx >= edge_count) begin
          rmw_ph <= '0; state <= S_POP;
        end else if (rmw_ph == 2'd2) begin
          if (q_we) tail <= tail + 1'b1;
          eidx <= eidx + 1'b1; rmw_ph <= '0;
        end else rmw_ph <= rmw_ph + 1'b1;
        S_OUT: if (out_free) begin
          res.kind <= drt_pkg::KIND_END; res.last <= 1'b1;
          res.value <= (op_r == drt_pkg::OP_SORT && lim != '0 && cnt < node_count)
                       ? 7'h7f : {1'b0, cnt};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign ret_idle = (state == S_IDLE);
  assign is_final = out_valid && last;

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    !ret_idle |-> !in_ready) else $error("input taken while busy");
  a_edge_bound: assert property (@(posedge clk) disable iff (rst)
    edge_count <= (EW+1)'(drt_pkg::MaxEdges)) else $error("edge count overflow");
  a_node_bound: assert property (@(posedge clk) disable iff (rst)
    node_count <= 6'(drt_pkg::MaxNodes)) else $error("node count overflow");
  a_final_then_idle: assert property (@(posedge clk) disable iff (rst)
    is_final |-> ret_idle) else $error("final result while scan runs");
endmodule

@@ bench/tb.sv @@
// Testbench for dag_ready_tracker_topo_sort: random and directed graph ops,
// with a built-in scheduler predictor checked result by result.
// Depends on drt_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb;
  typedef struct packed {
    logic [2:0] op;
    logic [5:0] a;
    logic [5:0] b;
    logic [5:0] lim;
  } graph_op_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [2:0] op = 0;
  logic [5:0] node_id = 0;
  logic [5:0] other_id = 0;
  logic [5:0] max_out = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] result_kind;
  logic [6:0] value;
  logic [5:0] node_total;
  logic last;

  dag_ready_tracker_topo_sort dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  graph_op_t pending_ops[$];
  drt_pkg::res_t expected_results[$];
  int errors = 0;
  int cycle = 0;
  int send_idle = 35;
  int recv_idle = 68;
  int hold_off = 0;
  bit drain_pause = 0;

  logic [drt_pkg::MaxNodes-1:0] done_mark;
  int nodes;
  int edges;
  logic [4:0] edge_src[drt_pkg::MaxEdges];
  logic [4:0] edge_dst[drt_pkg::MaxEdges];

  task automatic report(input string what, input drt_pkg::res_t got,
                        input drt_pkg::res_t want);
    $display("mismatch %s at cycle %0d: got %h want %h", what, cycle, got, want);
    errors++;
  endtask

  task automatic add_op(input graph_op_t t);
    pending_ops = {pending_ops, t};
  endtask

  function automatic bit ready_now(input int id);
    if (id >= nodes || done_mark[id]) return 0;
    for (int e = 0; e < edges; e++)
      if (edge_dst[e] == id && !done_mark[edge_src[e]]) return 0;
    return 1;
  endfunction

  task automatic put_result(input logic [1:0] kind, input int v, input bit fin);
    drt_pkg::res_t r;
    r.kind = kind;
    r.value = v[6:0];
    r.total = nodes[5:0];
    r.last = fin;
    expected_results = {expected_results, r};
  endtask

  task automatic schedule_op(input graph_op_t t);
    int v;
    int cnt;
    int head;
    int tail;
    int cur;
    int indeg[drt_pkg::MaxNodes];
    int fifo[drt_pkg::MaxNodes];
    v = -1;
    case (t.op)
      drt_pkg::OP_ADD_NODE: if (nodes < drt_pkg::MaxNodes) begin
        v = nodes;
        done_mark[nodes] = 0;
        nodes++;
      end
      drt_pkg::OP_ADD_EDGE: if (t.a < nodes && t.b < nodes
                                && edges < drt_pkg::MaxEdges) begin
        edge_src[edges] = t.a[4:0];
        edge_dst[edges] = t.b[4:0];
        edges++;
        v = 0;
      end
      drt_pkg::OP_MARK_DONE: if (t.a < nodes) begin
        done_mark[t.a] = 1;
        v = 0;
      end
      drt_pkg::OP_MARK_UNDONE: if (t.a < nodes) begin
        done_mark[t.a] = 0;
        v = 0;
      end
      drt_pkg::OP_QUERY: v = ready_now(t.a);
      drt_pkg::OP_LIST: begin
        cnt = 0;
        for (int i = 0; i < nodes && cnt < t.lim; i++)
          if (ready_now(i)) begin
            put_result(drt_pkg::KIND_ID, i, 0);
            cnt++;
          end
        put_result(drt_pkg::KIND_END, cnt, 1);
        return;
      end
      drt_pkg::OP_SORT: begin
        if (t.lim == 0) begin
          put_result(drt_pkg::KIND_END, 0, 1);
          return;
        end
        head = 0;
        tail = 0;
        cnt = 0;
        for (int i = 0; i < drt_pkg::MaxNodes; i++) indeg[i] = 0;
        for (int e = 0; e < edges; e++) indeg[edge_dst[e]]++;
        for (int i = 0; i < nodes; i++) if (indeg[i] == 0) fifo[tail++] = i;
        while (head < tail && cnt < t.lim) begin
          cur = fifo[head++];
          put_result(drt_pkg::KIND_ID, cur, 0);
          cnt++;
          for (int e = 0; e < edges; e++)
            if (edge_src[e] == cur && indeg[edge_dst[e]] > 0) begin
              indeg[edge_dst[e]]--;
              if (indeg[edge_dst[e]] == 0 && tail < drt_pkg::MaxNodes)
                fifo[tail++] = edge_dst[e];
            end
        end
        put_result(drt_pkg::KIND_END, cnt < nodes ? -1 : cnt, 1);
        return;
      end
      default: ;
    endcase
    put_result(drt_pkg::KIND_REPLY, v, 1);
  endtask

  function automatic graph_op_t make_op(input logic [2:0] o, input int a, input int b,
                                        input int l);
    graph_op_t t;
    t.op = o;
    t.a = a[5:0];
    t.b = b[5:0];
    t.lim = l[5:0];
    return t;
  endfunction

  function automatic graph_op_t random_op(input int spread);
    int r;
    int hi;
    r = $urandom_range(99);
    hi = (spread < 5) ? 63 : spread + 1;
    if (r < 12) return make_op(drt_pkg::OP_ADD_NODE, $urandom, $urandom, $urandom);
    if (r < 40) return make_op(drt_pkg::OP_ADD_EDGE, $urandom_range(hi),
                               $urandom_range(hi), $urandom);
    if (r < 55) return make_op(drt_pkg::OP_MARK_DONE, $urandom_range(hi), $urandom, $urandom);
    if (r < 63) return make_op(drt_pkg::OP_MARK_UNDONE, $urandom_range(hi), $urandom,
                               $urandom);
    if (r < 73) return make_op(drt_pkg::OP_QUERY, $urandom_range(hi), $urandom, $urandom);
    if (r < 84) return make_op(drt_pkg::OP_LIST, $urandom, $urandom, $urandom_range(63));
    if (r < 97) return make_op(drt_pkg::OP_SORT, $urandom, $urandom, $urandom_range(63));
    return make_op(drt_pkg::OP_SPARE, $urandom, $urandom, $urandom);
  endfunction

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 50000000) begin
      $display("** dag_ready_tracker_topo_sort: FAILED **");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (!in_valid || in_ready) begin
        if (pending_ops.size() > 0 && !drain_pause
            && $urandom_range(99) >= send_idle) begin
          graph_op_t t;
          t = pending_ops.pop_front();
          in_valid <= 1;
          op <= t.op;
          node_id <= t.a;
          other_id <= t.b;
          max_out <= t.lim;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // predict on transfer
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      schedule_op(make_op(op, node_id, other_id, max_out));
  end

  // receiver hold-off count
  always @(posedge clk) begin
    if (hold_off > 0) hold_off <= hold_off - 1;
  end

  // monitor and receiver
  always @(posedge clk) begin
    drt_pkg::res_t got;
    drt_pkg::res_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{result_kind, value, node_total, last};
        if (expected_results.size() == 0) begin
          report("unexpected", got, '0);
        end else begin
          want = expected_results.pop_front();
          if (got.kind != want.kind) report("result_kind", got, want);
          if (got.value != want.value) report("value", got, want);
          if (got.total != want.total) report("node_total", got, want);
          if (got.last != want.last) report("last", got, want);
        end
      end
      out_ready <= (hold_off > 0) ? 1'b0 : ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic wait_drained();
    while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    done_mark = '0;
    nodes = 0;
    edges = 0;
    repeat (4) @(posedge clk);
    rst <= 0;

    add_op(make_op(drt_pkg::OP_SORT, 0, 0, 5));
    add_op(make_op(drt_pkg::OP_LIST, 0, 0, 5));
    add_op(make_op(drt_pkg::OP_ADD_EDGE, 0, 0, 0));
    add_op(make_op(drt_pkg::OP_MARK_DONE, 0, 0, 0));
    for (int i = 0; i < 4; i++) add_op(make_op(drt_pkg::OP_ADD_NODE, 0, 0, 0));
    add_op(make_op(drt_pkg::OP_ADD_EDGE, 0, 1, 0));
    add_op(make_op(drt_pkg::OP_ADD_EDGE, 0, 1, 0));
    add_op(make_op(drt_pkg::OP_ADD_EDGE, 1, 2, 63));
    add_op(make_op(drt_pkg::OP_ADD_EDGE, 63, 4, 0));
    add_op(make_op(drt_pkg::OP_QUERY, 1, 0, 0));
    add_op(make_op(drt_pkg::OP_QUERY, 63, 63, 63));
    add_op(make_op(drt_pkg::OP_LIST, 0, 0, 0));
    add_op(make_op(drt_pkg::OP_LIST, 0, 0, 63));
    add_op(make_op(drt_pkg::OP_SORT, 0, 0, 0));
    add_op(make_op(drt_pkg::OP_SORT, 0, 0, 63));
    add_op(make_op(drt_pkg::OP_SORT, 0, 0, 2));
    add_op(make_op(drt_pkg::OP_MARK_DONE, 0, 0, 0));
    add_op(make_op(drt_pkg::OP_MARK_UNDONE, 0, 0, 0));
    add_op(make_op(drt_pkg::OP_MARK_UNDONE, 42, 0, 0));
    add_op(make_op(drt_pkg::OP_ADD_EDGE, 3, 3, 0));
    add_op(make_op(drt_pkg::OP_SORT, 0, 0, 63));
    add_op(make_op(drt_pkg::OP_SPARE, 63, 63, 63));

    // hold off the receiver while the sender keeps offering
    for (int i = 0; i < 10; i++) add_op(make_op(drt_pkg::OP_LIST, 0, 0, 63));
    @(posedge clk);
    hold_off <= 400;
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 35 : (ph == 1) ? 68 : 0;
      recv_idle = (ph == 0) ? 68 : (ph == 1) ? 35 : 0;
      for (int i = 0; i < 90; i++) begin
        if (nodes < 3 && $urandom_range(1))
          add_op(make_op(drt_pkg::OP_ADD_NODE, 0, 0, 0));
        add_op(random_op(nodes));
      end
      // sender pauses until every result is back
      while (pending_ops.size() > 45) @(posedge clk);
      drain_pause = 1;
      @(posedge clk);
      while (in_valid || expected_results.size() > 0) @(posedge clk);
      drain_pause = 0;
      wait_drained();
    end

    repeat (200) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("** dag_ready_tracker_topo_sort: PASSED **");
    else
      $display("** dag_ready_tracker_topo_sort: FAILED **");
    $finish;
  end
endmodule
